// ----- design/sss_pkg.sv -----
package sss_pkg;

  localparam int TEXT_W    = 8;
  localparam int START_W   = 16;
  localparam int LEN_W     = 5;
  localparam int NEEDLE_N  = 16;
  localparam int NEEDLE_W  = NEEDLE_N * TEXT_W;
  localparam int APB_DW    = 64;
  localparam int APB_AW    = 5;

  typedef enum logic [1:0] {
    REG_NEEDLE_LO  = 2'd0,
    REG_NEEDLE_HI  = 2'd1,
    REG_NEEDLE_LEN = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic               found;
    logic [START_W-1:0] match_start;
    logic               position_saturated;
  } result_t;

  // needle bytes past the register contents read as zero
  function automatic logic [TEXT_W-1:0] needle_byte(input logic [NEEDLE_W-1:0] needle,
                                                     input logic [LEN_W-1:0] idx);
    logic [TEXT_W-1:0] b;
    b = '0;
    if (32'(idx) < NEEDLE_N) begin
      b = needle[{idx[3:0], 3'b000} +: TEXT_W];
    end
    return b;
  endfunction

endpackage

// ----- design/sss_if.sv -----
interface sss_in_if;
  logic                        valid;
  logic                        ready;
  logic [sss_pkg::TEXT_W-1:0]  text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface sss_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [sss_pkg::START_W-1:0] match_start;
  logic                        position_saturated;

  modport source (output valid, output found, output match_start,
                  output position_saturated, input ready);
  modport sink (input valid, input found, input match_start,
                input position_saturated, output ready);
endinterface

// ----- design/sss_cell.sv -----
module sss_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sss_pkg::cell_ctrl_t        ctrl_i,
  input  logic [sss_pkg::TEXT_W-1:0] data_i,
  input  logic [sss_pkg::TEXT_W-1:0] needle_i,
  input  logic                       active_i,
  output logic [sss_pkg::TEXT_W-1:0] data_o,
  output logic                       match_o
);
  import sss_pkg::*;

  logic [TEXT_W-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (ctrl_i.clear) begin
      data_q <= '0;
    end else if (ctrl_i.shift) begin
      data_q <= data_i;
    end
  end

  assign data_o  = data_q;
  // cells beyond the needle length do not take part
  assign match_o = !active_i || (data_q == needle_i);

endmodule

// ----- design/substring_search_stream.sv -----
// a result is registered in the output register, or in the skid entry while the output register is held
// throughput: one text byte per cycle while the skid entry is empty, set by the parallel compare over the cell row
// a two-entry output stage keeps requests flowing while a result waits
// reset: asynchronous, clears the needle registers, the window, position and flags
// a zero byte returns the text state to its reset value, the needle is kept
module substring_search_stream #(
  parameter int MAX_NEEDLE    = 16,
  parameter int POSITION_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sss_pkg::APB_AW-1:0] paddr,
  input  logic [sss_pkg::APB_DW-1:0] pwdata,
  output logic [sss_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  sss_in_if.sink                     in_i,
  sss_out_if.source                  out_o
);
  import sss_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  logic [APB_DW-1:0]        needle_lo_q, needle_hi_q;
  logic [LEN_W-1:0]         needle_len_q;
  logic [NEEDLE_W-1:0]      needle;
  logic [LEN_W-1:0]         len_use;
  reg_idx_e                 reg_idx;
  logic                     cfg_wr;

  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     answered_q, answered_d;
  logic                     sat_q, sat_d;

  logic [TEXT_W-1:0]        win [MAX_NEEDLE];
  logic [MAX_NEEDLE-1:0]    eq;
  cell_ctrl_t               cell_ctrl;

  logic                     in_fire, is_end, len_zero, pos_ok, win_hit, new_res;
  logic [POSITION_BITS-1:0] start_pos;
  result_t                  res, out_q, out_d, skid_q, skid_d;
  logic                     out_v_q, out_v_d, skid_v_q, skid_v_d, out_fire;

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_lo_q  <= '0;
      needle_hi_q  <= '0;
      needle_len_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_NEEDLE_LO:  needle_lo_q  <= pwdata;
        REG_NEEDLE_HI:  needle_hi_q  <= pwdata;
        REG_NEEDLE_LEN: needle_len_q <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NEEDLE_LO:  prdata = needle_lo_q;
      REG_NEEDLE_HI:  prdata = needle_hi_q;
      REG_NEEDLE_LEN: prdata = APB_DW'(needle_len_q);
      default:        prdata = '0;
    endcase
  end

  assign needle  = {needle_hi_q, needle_lo_q};
  assign len_use = (32'(needle_len_q) > MAX_NEEDLE) ? LEN_W'(MAX_NEEDLE) : needle_len_q;

  // window compare: cell k holds the byte k places back
  assign win[0] = in_i.text_byte;
  assign eq[0]  = (in_i.text_byte == needle_byte(needle, len_use - LEN_W'(1)));

  for (genvar k = 1; k < MAX_NEEDLE; k++) begin : g_cell
    sss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .data_i   (win[k-1]),
      .needle_i (needle_byte(needle, LEN_W'(32'(len_use) - k - 1))),
      .active_i (k < 32'(len_use)),
      .data_o   (win[k]),
      .match_o  (eq[k])
    );
  end

  // request handling
  assign in_fire   = in_i.valid && in_i.ready;
  assign is_end    = (in_i.text_byte == '0);
  assign len_zero  = (len_use == '0);
  assign pos_ok    = ({1'b0, pos_q} + (POSITION_BITS+1)'(1)) >= (POSITION_BITS+1)'(len_use);
  assign win_hit   = pos_ok && (&eq);
  assign new_res   = in_fire && !answered_q && (is_end || len_zero || win_hit);
  assign start_pos = pos_q - POSITION_BITS'(len_use) + POSITION_BITS'(1);

  always_comb begin
    res.found              = is_end ? len_zero : 1'b1;
    res.match_start        = (!is_end && !len_zero) ? START_W'(start_pos) : '0;
    res.position_saturated = sat_q;
  end

  always_comb begin
    pos_d           = pos_q;
    answered_d      = answered_q;
    sat_d           = sat_q;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.clear = 1'b0;
    if (in_fire) begin
      if (is_end) begin
        pos_d           = '0;
        answered_d      = 1'b0;
        sat_d           = 1'b0;
        cell_ctrl.clear = 1'b1;
      end else begin
        cell_ctrl.shift = 1'b1;
        if (new_res) begin
          answered_d = 1'b1;
        end
        if (pos_q == POS_MAX) begin
          sat_d = 1'b1;
        end else begin
          pos_d = pos_q + POSITION_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      answered_q <= 1'b0;
      sat_q      <= 1'b0;
    end else begin
      pos_q      <= pos_d;
      answered_q <= answered_d;
      sat_q      <= sat_d;
    end
  end

  // output register plus skid entry
  assign out_fire = out_v_q && out_o.ready;
  assign in_i.ready = !skid_v_q;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (out_fire) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (new_res) begin
      if (!out_v_q || out_fire) begin
        out_d   = res;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res;
        skid_v_d = 1'b1;
      end
    end else if (out_fire) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid              = out_v_q;
  assign out_o.found              = out_q.found;
  assign out_o.match_start        = out_q.match_start;
  assign out_o.position_saturated = out_q.position_saturated;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry held while output register empty");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && is_end) |=> (!answered_q && pos_q == '0 && !sat_q))
    else $error("text state not cleared after end of text");

  a_hit_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (new_res && !is_end) |=> answered_q)
    else $error("result given without marking the text answered");

  a_sat_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (pos_q == POS_MAX))
    else $error("saturation flag set below the position maximum");

endmodule
